[hdl/assert_macros.svh]
// Assertion macros shared by the least common multiple unit.
// Both expect signals clk and arst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lcm_pkg.sv]
// Package for the least common multiple unit: widths, FSM states, datapath commands
// and the status bundle. No dependencies.
`default_nettype none
package lcm_pkg;
	localparam int WIDTH   = 32;
	localparam int FIELD_W = 32;
	localparam int CNT_W   = $clog2(WIDTH);

	typedef logic [WIDTH-1:0]   word_t;
	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_TWOS, ST_ODDX, ST_GCD, ST_DIV, ST_MULI, ST_MUL, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_LOAD, CMD_TWOS, CMD_ODDX, CMD_GCD,
		CMD_DIVI, CMD_DIV, CMD_MULI, CMD_MUL, CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic op_zero;
		logic both_even;
		logic x_even;
		logic y_zero;
		logic cnt_last;
	} status_t;
endpackage
`default_nettype wire

[hdl/lcm_in_if.sv]
// Operand channel: valid/ready handshake carrying the two operands.
// Depends on lcm_pkg.
`default_nettype none
interface lcm_in_if
	import lcm_pkg::*;
();
	logic   valid;
	logic   ready;
	field_t first_value;
	field_t second_value;

	modport source (output valid, output first_value, output second_value, input ready);
	modport sink   (input valid, input first_value, input second_value, output ready);
endinterface
`default_nettype wire

[hdl/lcm_out_if.sv]
// Result channel: valid/ready handshake carrying the multiple and the overflow flag.
// Depends on lcm_pkg.
`default_nettype none
interface lcm_out_if
	import lcm_pkg::*;
();
	logic   valid;
	logic   ready;
	field_t multiple;
	logic   overflow;

	modport source (output valid, output multiple, output overflow, input ready);
	modport sink   (input valid, input multiple, input overflow, output ready);
endinterface
`default_nettype wire

[hdl/lcm_datapath.sv]
// Datapath of the least common multiple unit: binary GCD, restoring divider,
// shift-add multiplier and result register. Depends on lcm_pkg.
`default_nettype none
module lcm_datapath
	import lcm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cmd_t    cmd,
	input  wire field_t  first_value,
	input  wire field_t  second_value,
	output status_t      status,
	output field_t       multiple,
	output logic         overflow
);
	word_t  a_q, b_q, x_q, y_q, rem_q;
	cnt_t   twos_q, cnt_q;
	field_t multiple_q;
	logic   overflow_q;

	logic [WIDTH:0] trial, diff, sum;
	logic           ge;

	always_comb begin
		trial = {rem_q, x_q[WIDTH-1]};
		diff  = trial - {1'b0, y_q};
		ge    = trial >= {1'b0, y_q};
		sum   = {1'b0, rem_q} + (x_q[0] ? {1'b0, b_q} : '0);
	end

	always_comb begin
		status.op_zero   = (a_q == '0) || (b_q == '0);
		status.both_even = !x_q[0] && !y_q[0];
		status.x_even    = !x_q[0];
		status.y_zero    = y_q == '0;
		status.cnt_last  = cnt_q == CNT_W'(WIDTH - 1);
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				a_q    <= WIDTH'(first_value);
				b_q    <= WIDTH'(second_value);
				x_q    <= WIDTH'(first_value);
				y_q    <= WIDTH'(second_value);
				twos_q <= '0;
			end
			CMD_TWOS: begin
				x_q    <= x_q >> 1;
				y_q    <= y_q >> 1;
				twos_q <= twos_q + 1'b1;
			end
			CMD_ODDX: x_q <= x_q >> 1;
			CMD_GCD: begin
				if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q > y_q) begin
					x_q <= y_q;
					y_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
			CMD_DIVI: begin
				y_q   <= x_q << twos_q;
				x_q   <= a_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			CMD_DIV: begin
				rem_q <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
				x_q   <= {x_q[WIDTH-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			CMD_MULI: begin
				rem_q <= '0;
				cnt_q <= '0;
			end
			CMD_MUL: begin
				rem_q <= sum[WIDTH:1];
				x_q   <= {sum[0], x_q[WIDTH-1:1]};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multiple_q <= '0;
			overflow_q <= 1'b0;
		end else if (cmd == CMD_FINISH) begin
			if (status.op_zero) begin
				multiple_q <= '0;
				overflow_q <= 1'b0;
			end else if (rem_q != '0) begin
				multiple_q <= '0;
				overflow_q <= 1'b1;
			end else begin
				multiple_q <= FIELD_W'(x_q);
				overflow_q <= 1'b0;
			end
		end
	end

	assign multiple = multiple_q;
	assign overflow = overflow_q;
endmodule
`default_nettype wire

[hdl/lcm_ctrl.sv]
// Controller of the least common multiple unit: sequences the datapath and owns
// the handshakes. Depends on lcm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lcm_ctrl
	import lcm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);
	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   in_xfer;

	assign out_free = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = ST_TWOS;
				end
			end
			ST_TWOS: begin
				priority if (status.op_zero) begin
					state_d = ST_DONE;
				end else if (status.both_even) begin
					cmd = CMD_TWOS;
				end else begin
					state_d = ST_ODDX;
				end
			end
			ST_ODDX: begin
				if (status.x_even) begin
					cmd = CMD_ODDX;
				end else begin
					state_d = ST_GCD;
				end
			end
			ST_GCD: begin
				if (status.y_zero) begin
					cmd     = CMD_DIVI;
					state_d = ST_DIV;
				end else begin
					cmd = CMD_GCD;
				end
			end
			ST_DIV: begin
				cmd = CMD_DIV;
				if (status.cnt_last) begin
					state_d = ST_MULI;
				end
			end
			ST_MULI: begin
				cmd     = CMD_MULI;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd = CMD_MUL;
				if (status.cnt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd     = CMD_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == CMD_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`LCM_ASSERT_NEXT(a_load_starts, in_xfer, state_q == ST_TWOS, "transfer did not start GCD")
	`LCM_ASSERT_NOW(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result raised outside done")
	`LCM_ASSERT_NEXT(a_mul_ends, (state_q == ST_MUL) && status.cnt_last, state_q == ST_DONE, "multiply overran")
endmodule
`default_nettype wire

[hdl/least_common_multiple_unit.sv]
// Top level of the least common multiple unit: joins controller and datapath to the
// operand and result channels. Depends on lcm_pkg, lcm_in_if, lcm_out_if, lcm_ctrl, lcm_datapath.
//
//   channel    dir   payload
//   operands   in    first_value[31:0], second_value[31:0]
//   result     out   multiple[31:0], overflow
//
// One item at a time. Each item runs the twos, odd-part and GCD shift-subtract loops,
// then the restoring divide and the shift-add multiply, then a finish step that writes
// the result register. A zero operand skips the loops and goes straight to the finish.
// The result register lets the next item be taken while a result still waits; a second
// finished item holds in the done state until the waiting result transfers.
// Reset clears the controller and the result valid.
`default_nettype none
module least_common_multiple_unit
	import lcm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lcm_in_if.sink    operands,
	lcm_out_if.source result
);
	cmd_t    cmd;
	status_t status;
	logic    in_ready;
	logic    out_valid;
	field_t  multiple;
	logic    overflow;

	lcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	lcm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.first_value  (operands.first_value),
		.second_value (operands.second_value),
		.status       (status),
		.multiple     (multiple),
		.overflow     (overflow)
	);

	assign operands.ready  = in_ready;
	assign result.valid    = out_valid;
	assign result.multiple = multiple;
	assign result.overflow = overflow;
endmodule
`default_nettype wire

[test/least_common_multiple_unit_tb.sv]
// Testbench for least_common_multiple_unit: directed table then random operand pairs,
// each result checked against its typed row or a Euclid-based LCM predictor under varied idling.
// Depends on lcm_pkg, lcm_in_if, lcm_out_if and the unit itself.
`default_nettype none
module least_common_multiple_unit_tb;
	import lcm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		field_t multiple;
		logic   overflow;
	} lcm_res_t;

	typedef struct packed {
		field_t a;
		field_t b;
		logic   typed;
		field_t multiple;
		logic   overflow;
	} stim_row_t;

	localparam int N_DIRECTED = 22;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
		'{32'h8000_0000, 32'h0000_0002, 1'b1, 32'h8000_0000, 1'b0},
		'{32'h8000_0000, 32'h0000_0003, 1'b1, 32'h0000_0000, 1'b1},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000, 1'b1},
		'{32'h0001_0000, 32'h0001_0001, 1'b1, 32'h0000_0000, 1'b1},
		'{32'h0000_FFFF, 32'h0001_0001, 1'b1, 32'hFFFF_FFFF, 1'b0},
		'{32'h0000_000C, 32'h0000_0012, 1'b0, 32'h0000_0000, 1'b0},
		'{32'h0000_0007, 32'h0000_000D, 1'b0, 32'h0000_0000, 1'b0},
		'{32'h0000_0006, 32'h0000_0004, 1'b0, 32'h0000_0000, 1'b0},
		'{32'h3B9A_CA07, 32'h3B80_0001, 1'b0, 32'h0000_0000, 1'b0},
		'{32'hDEAD_BEEF, 32'h1234_5678, 1'b0, 32'h0000_0000, 1'b0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0000_0000, 1'b0},
		'{32'h7FFF_FFFF, 32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0},
		'{32'h0000_0030, 32'h0000_00B4, 1'b0, 32'h0000_0000, 1'b0},
		'{32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0}
	};

	logic clk;
	logic arst_n;

	lcm_in_if  op_if ();
	lcm_out_if res_if ();

	least_common_multiple_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (op_if),
		.result   (res_if)
	);

	int       src_idle;
	int       sink_stall;
	int       hold_left;
	int       errors;
	logic     cur_typed;
	lcm_res_t cur_typed_res;
	lcm_res_t pending_lcm_q[$];

	function automatic lcm_res_t lcm_of(field_t a_in, field_t b_in);
		word_t            a;
		word_t            b;
		word_t            x;
		word_t            y;
		word_t            t;
		word_t            q;
		logic [2*WIDTH-1:0] prod;
		lcm_res_t         r;
		a = a_in;
		b = b_in;
		r = '0;
		if (a != 0 && b != 0) begin
			x = a;
			y = b;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			q = a / x;
			prod = {{WIDTH{1'b0}}, q} * {{WIDTH{1'b0}}, b};
			if (|prod[2*WIDTH-1:WIDTH]) begin
				r.overflow = 1'b1;
			end else begin
				r.multiple = prod[WIDTH-1:0];
			end
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("FAIL");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_if.ready = 1'b0;
			hold_left--;
		end else begin
			res_if.ready = ($urandom_range(0, 99) >= sink_stall);
		end
	end

	always @(posedge clk) begin
		lcm_res_t want;
		if (res_if.valid && res_if.ready) begin
			if (pending_lcm_q.size() == 0) begin
				$display("%0t: result %h overflow %b with nothing expected",
					$time, res_if.multiple, res_if.overflow);
				errors++;
			end else begin
				want = pending_lcm_q.pop_front();
				if (res_if.multiple !== want.multiple) begin
					$display("%0t: multiple expected %h got %h",
						$time, want.multiple, res_if.multiple);
					errors++;
				end
				if (res_if.overflow !== want.overflow) begin
					$display("%0t: overflow expected %b got %b",
						$time, want.overflow, res_if.overflow);
					errors++;
				end
			end
		end
		if (op_if.valid && op_if.ready) begin
			if (cur_typed)
				pending_lcm_q.push_back(cur_typed_res);
			else
				pending_lcm_q.push_back(lcm_of(op_if.first_value, op_if.second_value));
		end
	end

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic offer(field_t a, field_t b, logic typed, field_t m, logic o);
		while ($urandom_range(0, 99) < src_idle) begin
			op_if.valid = 1'b0;
			@(negedge clk);
		end
		op_if.first_value  = a;
		op_if.second_value = b;
		cur_typed          = typed;
		cur_typed_res      = '{multiple: m, overflow: o};
		op_if.valid        = 1'b1;
		do @(posedge clk); while (!op_if.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		op_if.valid = 1'b0;
		while (pending_lcm_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(int n);
		field_t a;
		field_t b;
		field_t g;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					a = $urandom;
					b = $urandom;
				end
				1, 2: begin
					a = $urandom_range(1, 65535);
					b = $urandom_range(1, 65535);
				end
				3, 4: begin
					g = $urandom_range(1, 4095);
					a = g * $urandom_range(1, 1 << 20);
					b = g * $urandom_range(1, 1 << 20);
				end
				5: begin
					a = $urandom >> $urandom_range(0, 31);
					b = $urandom >> $urandom_range(0, 31);
				end
				6: begin
					a = $urandom;
					b = 0;
					if ($urandom_range(0, 1)) begin
						b = a;
						a = 0;
					end
				end
				7: begin
					b = $urandom >> $urandom_range(0, 31);
					a = b * $urandom_range(1, 8);
				end
				8: begin
					a = ~field_t'($urandom_range(0, 255));
					b = $urandom_range(1, 256);
				end
				default: begin
					a = $urandom;
					b = a ^ (field_t'(1) << $urandom_range(0, 31));
				end
			endcase
			offer(a, b, 1'b0, '0, 1'b0);
		end
	endtask

	initial begin
		errors             = 0;
		src_idle           = 0;
		sink_stall         = 0;
		hold_left          = 0;
		cur_typed          = 1'b0;
		cur_typed_res      = '0;
		arst_n             = 1'b0;
		op_if.valid        = 1'b0;
		op_if.first_value  = '0;
		op_if.second_value = '0;
		res_if.ready       = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			offer(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].typed,
				DIRECTED[i].multiple, DIRECTED[i].overflow);
		drain();

		src_idle = 0;  sink_stall = 0;  run_random(500); drain();
		src_idle = 77; sink_stall = 0;  run_random(500); drain();
		src_idle = 0;  sink_stall = 77; run_random(500); drain();
		src_idle = 21; sink_stall = 21; run_random(500); drain();

		// hold the result side off long enough for the input to back up
		src_idle  = 0;
		sink_stall = 0;
		hold_left = 600;
		run_random(24);
		drain();

		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
